// ----- rtl/microcode_control_word_decoder_unit_defines.svh -----
// assertion macros shared by the checker
`ifndef MICROCODE_CONTROL_WORD_DECODER_UNIT_DEFINES_SVH
`define MICROCODE_CONTROL_WORD_DECODER_UNIT_DEFINES_SVH

// same-cycle implication
`define MCWD_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
        else $error("mcwd assertion failed");

// next-cycle implication
`define MCWD_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
        else $error("mcwd assertion failed");

`endif

// ----- rtl/mcwd_pkg.sv -----
package mcwd_pkg;

    localparam int FLAG_W   = 4;
    localparam int OPCODE_W = 7;
    localparam int STEP_W   = 4;
    localparam int CW_W     = 24;

    typedef logic [CW_W-1:0] ctrl_word_t;

    typedef struct packed {
        logic                irq_pending;
        logic [FLAG_W-1:0]   status_flags;
        logic [OPCODE_W-1:0] opcode;
        logic [STEP_W-1:0]   microstep;
    } req_word_t;

    // control lines
    localparam ctrl_word_t W_CLR    = 24'h000001;
    localparam ctrl_word_t W_D0     = 24'h000002;
    localparam ctrl_word_t W_D1     = 24'h000004;
    localparam ctrl_word_t W_D2     = 24'h000008;
    localparam ctrl_word_t W_A0     = 24'h000010;
    localparam ctrl_word_t W_A1     = 24'h000020;
    localparam ctrl_word_t W_B0     = 24'h000040;
    localparam ctrl_word_t W_B1     = 24'h000080;
    localparam ctrl_word_t W_CLRIRQ = 24'h000100;
    localparam ctrl_word_t W_SPINC  = 24'h000200;
    localparam ctrl_word_t W_ADRIN  = 24'h000400;
    localparam ctrl_word_t W_MEMIN  = 24'h000800;
    localparam ctrl_word_t W_PCLD   = 24'h001000;
    localparam ctrl_word_t W_RDLD   = 24'h002000;
    localparam ctrl_word_t W_XLD    = 24'h004000;
    localparam ctrl_word_t W_YLD    = 24'h008000;
    localparam ctrl_word_t W_IMM    = 24'h010000;
    localparam ctrl_word_t W_FLLD   = 24'h020000;
    localparam ctrl_word_t W_M      = 24'h040000;
    localparam ctrl_word_t W_S0     = 24'h080000;
    localparam ctrl_word_t W_S1     = 24'h100000;
    localparam ctrl_word_t W_S2     = 24'h200000;
    localparam ctrl_word_t W_S3     = 24'h400000;
    localparam ctrl_word_t W_CIN    = 24'h800000;

    localparam ctrl_word_t LOW_LINES = W_CLR | W_SPINC | W_RDLD | W_XLD | W_YLD | W_FLLD
                                     | W_ADRIN | W_PCLD | W_CLRIRQ;

endpackage

// ----- rtl/mcwd_req_if.sv -----
interface mcwd_req_if;
    import mcwd_pkg::*;

    logic                valid;
    logic                ready;
    logic                irq_pending;
    logic [FLAG_W-1:0]   status_flags;
    logic [OPCODE_W-1:0] opcode;
    logic [STEP_W-1:0]   microstep;

    modport source (output valid, irq_pending, status_flags, opcode, microstep, input ready);
    modport sink   (input valid, irq_pending, status_flags, opcode, microstep, output ready);
endinterface

// ----- rtl/mcwd_rsp_if.sv -----
interface mcwd_rsp_if;
    import mcwd_pkg::*;

    logic            valid;
    logic            ready;
    logic [CW_W-1:0] control_word;

    modport source (output valid, control_word, input ready);
    modport sink   (input valid, control_word, output ready);
endinterface

// ----- rtl/mcwd_in_stage.sv -----
module mcwd_in_stage (
    input  logic               clk,
    input  logic               rst_n,
    mcwd_req_if.sink           request,
    input  logic               advance,
    output logic               valid,
    output mcwd_pkg::req_word_t word
);
    import mcwd_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    req_word_t word_reg;
    logic      take;

    assign request.ready = !valid_reg || advance;
    assign take          = request.valid && request.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            word_reg <= '{irq_pending:  request.irq_pending,
                          status_flags: request.status_flags,
                          opcode:       request.opcode,
                          microstep:    request.microstep};
        end
    end

    assign valid = valid_reg;
    assign word  = word_reg;
endmodule

// ----- rtl/mcwd_decode.sv -----
module mcwd_decode (
    input  mcwd_pkg::req_word_t  word,
    output mcwd_pkg::ctrl_word_t control_word
);
    import mcwd_pkg::*;

    // bus source and address field codes
    localparam ctrl_word_t D_ALU   = W_D0;
    localparam ctrl_word_t D_SHIFT = W_D1;
    localparam ctrl_word_t D_MEM   = W_D1 | W_D0;
    localparam ctrl_word_t D_PC    = W_D2;
    localparam ctrl_word_t D_IR    = W_D2 | W_D0;
    localparam ctrl_word_t D_FLAGS = W_D2 | W_D1;
    localparam ctrl_word_t D_CONST = W_D2 | W_D1 | W_D0;
    localparam ctrl_word_t A_PC    = W_A0 | W_ADRIN;
    localparam ctrl_word_t A_ALU   = W_A1 | W_ADRIN;
    localparam ctrl_word_t IR_LOAD = W_A1 | W_A0;
    localparam ctrl_word_t SP_DEC  = W_SPINC | W_S0;
    localparam ctrl_word_t FL_BUS  = W_FLLD | W_IMM;
    localparam ctrl_word_t FETCHW  = IR_LOAD | D_MEM | W_XLD | W_YLD;
    localparam ctrl_word_t ENDW    = A_PC | W_CLR;

    // alu operation codes
    localparam ctrl_word_t ALU_Y   = W_M | W_S3 | W_S1;
    localparam ctrl_word_t ALU_X   = W_M | W_S3 | W_S2 | W_S1 | W_S0;
    localparam ctrl_word_t ALU_XM1 = W_S3 | W_S2 | W_S1 | W_S0 | W_CIN;
    localparam ctrl_word_t ALU_AND = W_M | W_S3 | W_S1 | W_S0;
    localparam ctrl_word_t ALU_OR  = W_M | W_S3 | W_S2 | W_S1;
    localparam ctrl_word_t ALU_XOR = W_M | W_S2 | W_S1;
    localparam ctrl_word_t ALU_ADD = W_S3 | W_S0 | W_CIN;
    localparam ctrl_word_t ALU_SUB = W_S2 | W_S1;

    // opcode groups and single opcodes
    localparam logic [6:0] OPC_SHIFT_BASE = 7'd48;
    localparam logic [6:0] OPC_SHL_BASE   = 7'd64;
    localparam logic [6:0] OPC_SHR_BASE   = 7'd80;
    localparam logic [6:0] OPC_MISC_BASE  = 7'd96;
    localparam logic [6:0] OPC_LD         = 7'd96;
    localparam logic [6:0] OPC_LDB        = 7'd97;
    localparam logic [6:0] OPC_ST         = 7'd98;
    localparam logic [6:0] OPC_STB        = 7'd99;
    localparam logic [6:0] OPC_LDBL       = 7'd100;
    localparam logic [6:0] OPC_LDBH       = 7'd101;
    localparam logic [6:0] OPC_PUSH       = 7'd102;
    localparam logic [6:0] OPC_POP        = 7'd103;
    localparam logic [6:0] OPC_JMP_MEM    = 7'b1101000;
    localparam logic [6:0] OPC_JMP_REG    = 7'd112;
    localparam logic [6:0] OPC_CALL       = 7'd120;
    localparam logic [6:0] OPC_RET        = 7'd121;
    localparam logic [6:0] OPC_PUSHF      = 7'd122;
    localparam logic [6:0] OPC_POPF       = 7'd123;

    localparam logic [2:0] FN_NONE = 3'd0;
    localparam logic [2:0] FN_AND  = 3'd1;
    localparam logic [2:0] FN_OR   = 3'd2;
    localparam logic [2:0] FN_XOR  = 3'd3;
    localparam logic [2:0] FN_ADD  = 3'd4;
    localparam logic [2:0] FN_SUB  = 3'd5;
    localparam logic [2:0] FN_ADC  = 3'b110;
    localparam logic [2:0] FN_SBB  = 3'b111;

    localparam logic [2:0] CC_ALWAYS = 3'd0;
    localparam logic [2:0] CC_Z      = 3'd1;
    localparam logic [2:0] CC_NZ     = 3'd2;
    localparam logic [2:0] CC_C      = 3'd3;
    localparam logic [2:0] CC_NC     = 3'd4;
    localparam logic [2:0] CC_ZB     = 3'd5;
    localparam logic [2:0] CC_LT     = 3'd6;
    localparam logic [2:0] CC_LE     = 3'd7;

    function automatic ctrl_word_t alu_fn(input logic [2:0] f);
        ctrl_word_t r;
        case (f)
            FN_NONE: r = '0;
            FN_AND:  r = ALU_AND;
            FN_OR:   r = ALU_OR;
            FN_XOR:  r = ALU_XOR;
            FN_ADD:  r = ALU_ADD;
            FN_SUB:  r = ALU_SUB;
            FN_ADC:  r = ALU_ADD;
            FN_SBB:  r = ALU_SUB;
            default: r = '0;
        endcase
        return r;
    endfunction

    // template entry before inversion of the active-low lines
    function automatic ctrl_word_t template_word(input logic [6:0] op, input logic [3:0] step);
        ctrl_word_t w;
        ctrl_word_t fin;
        ctrl_word_t a1;
        ctrl_word_t mid;
        ctrl_word_t last;
        ctrl_word_t lea;
        ctrl_word_t stw;
        logic [2:0] mode;
        logic [2:0] f;
        logic [3:0] n;
        w    = '0;
        mode = op[5:3];
        f    = op[2:0];
        n    = op[3:0];
        fin  = '0;
        a1   = '0;
        mid  = '0;
        last = '0;
        lea  = D_MEM | W_B0 | W_IMM | W_YLD | ALU_ADD | A_ALU;
        stw  = ALU_Y | D_ALU | W_MEMIN | W_B1 | ENDW;
        if (step == 4'd0)
        begin
            w = FETCHW;
        end
        else if (op < OPC_SHIFT_BASE)
        begin
            fin = (mode < 3'd4) ? (alu_fn(f) | D_ALU | W_RDLD | W_FLLD | ENDW)
                                : (alu_fn(f) | D_ALU | W_MEMIN | W_B1 | W_FLLD | ENDW);
            case (mode)
                3'd0:
                begin
                    if (f == FN_NONE)
                        w = (step == 4'd1) ? (ALU_X | D_ALU | W_RDLD | ENDW) : '0;
                    else if (step == 4'd1)
                        w = D_MEM | W_B0 | W_YLD;
                    else if (step == 4'd2)
                        w = fin;
                end
                3'd1:
                begin
                    if (f == FN_NONE)
                        w = (step == 4'd1) ? (D_MEM | W_B0 | W_RDLD | ENDW) : '0;
                    else if (step == 4'd1)
                        w = D_MEM | W_B0 | W_IMM | W_YLD;
                    else if (step == 4'd2)
                        w = fin;
                end
                3'd2, 3'd3:
                begin
                    a1 = D_MEM | W_B0 | W_YLD | ALU_Y | A_ALU | ((mode == 3'd2) ? W_IMM : '0);
                    if (step == 4'd1)
                        w = a1;
                    else if (f == FN_NONE)
                        w = (step == 4'd2) ? (D_MEM | W_B1 | W_RDLD | ENDW) : '0;
                    else if (step == 4'd2)
                        w = D_MEM | W_B1 | W_IMM | W_YLD;
                    else if (step == 4'd3)
                        w = fin;
                end
                default:
                begin
                    if (step == 4'd1)
                        w = (mode == 3'd4) ? (D_MEM | W_B0 | W_IMM | W_XLD | ALU_X | A_ALU)
                                           : (D_MEM | W_B0 | W_YLD | ALU_X | A_ALU);
                    else if (f == FN_NONE)
                        w = (step == 4'd2) ? (ALU_Y | D_ALU | W_MEMIN | W_B1 | ENDW) : '0;
                    else if (step == 4'd2)
                        w = D_MEM | W_B1 | W_IMM | W_XLD;
                    else if (step == 4'd3)
                        w = fin;
                end
            endcase
        end
        else if (op < OPC_MISC_BASE)
        begin
            if (op < OPC_SHL_BASE)
            begin
                mid  = ALU_ADD | D_ALU | W_IMM | W_XLD | W_YLD;
                last = ALU_ADD | D_ALU | W_RDLD | W_FLLD | ENDW;
            end
            else
            begin
                mid  = ALU_X | D_SHIFT | W_IMM | W_XLD;
                last = ALU_X | D_SHIFT | W_RDLD | W_IMM | W_XLD | W_FLLD | ENDW;
                if (op >= OPC_SHR_BASE)
                begin
                    mid  = mid | W_CIN;
                    last = last | W_CIN;
                end
            end
            if (n == 4'd0)
                w = (step == 4'd1) ? ENDW : '0;
            else if (step == n)
                w = last;
            else if (step < n)
                w = mid;
        end
        else
        begin
            case (op)
                OPC_LD:
                    case (step)
                        4'd1:    w = lea;
                        4'd2:    w = D_MEM | W_B1 | W_RDLD | ENDW;
                        default: w = '0;
                    endcase
                OPC_LDB:
                    case (step)
                        4'd1:    w = lea;
                        4'd2:    w = D_MEM | W_B1 | W_B0 | W_RDLD | ENDW;
                        default: w = '0;
                    endcase
                OPC_ST:
                    case (step)
                        4'd1:    w = lea;
                        4'd2:    w = D_IR | W_YLD;
                        4'd3:    w = stw;
                        default: w = '0;
                    endcase
                OPC_STB:
                    case (step)
                        4'd1:    w = lea;
                        4'd2:    w = D_IR | W_YLD;
                        4'd3:    w = D_MEM | W_B1 | W_RDLD;
                        4'd4:    w = stw;
                        default: w = '0;
                    endcase
                OPC_LDBL:
                    case (step)
                        4'd1:    w = lea;
                        4'd2:    w = D_MEM | W_B0 | W_RDLD | ENDW;
                        default: w = '0;
                    endcase
                OPC_LDBH:
                    case (step)
                        4'd1:    w = lea;
                        4'd2:    w = D_MEM | W_RDLD | ENDW;
                        default: w = '0;
                    endcase
                OPC_PUSH:
                    case (step)
                        4'd1:    w = SP_DEC | D_MEM | W_B0 | W_YLD | ALU_XM1 | A_ALU;
                        4'd2:    w = stw;
                        default: w = '0;
                    endcase
                OPC_POP:
                    case (step)
                        4'd1:    w = ALU_X | A_ALU;
                        4'd2:    w = W_SPINC | D_MEM | W_B1 | W_RDLD | ENDW;
                        default: w = '0;
                    endcase
                OPC_CALL:
                    case (step)
                        4'd1:    w = D_MEM | W_B0 | W_IMM | W_YLD | ALU_XM1 | A_ALU;
                        4'd2:    w = SP_DEC | D_PC | W_MEMIN | W_B1;
                        4'd3:    w = ALU_Y | D_ALU | W_PCLD | A_ALU | W_CLR;
                        default: w = '0;
                    endcase
                OPC_RET:
                    case (step)
                        4'd1:    w = ALU_X | A_ALU;
                        4'd2:    w = W_SPINC | D_MEM | W_B1 | W_PCLD | ENDW;
                        default: w = '0;
                    endcase
                OPC_PUSHF:
                    case (step)
                        4'd1:    w = SP_DEC | ALU_XM1 | A_ALU;
                        4'd2:    w = D_FLAGS | W_MEMIN | W_B1 | ENDW;
                        default: w = '0;
                    endcase
                OPC_POPF:
                    case (step)
                        4'd1:    w = ALU_X | A_ALU;
                        4'd2:    w = W_SPINC | D_MEM | W_B1 | FL_BUS | ENDW;
                        default: w = '0;
                    endcase
                default:
                begin
                    if (step == 4'd1)
                    begin
                        if (op >= OPC_JMP_MEM && op < OPC_JMP_REG)
                            w = D_MEM | W_B0 | ENDW;
                        else if (op >= OPC_JMP_REG && op < OPC_CALL)
                            w = ALU_X | D_ALU | ENDW;
                        else
                            w = ENDW;
                    end
                end
            endcase
        end
        return w;
    endfunction

    function automatic ctrl_word_t irq_word(input logic [3:0] step);
        ctrl_word_t r;
        case (step)
            4'd0:    r = D_CONST | W_XLD | ALU_XM1 | A_ALU;
            4'd1:    r = SP_DEC | D_PC | W_MEMIN | W_B1;
            4'd2:    r = D_CONST | W_PCLD | A_PC | W_CLRIRQ | W_CLR;
            default: r = '0;
        endcase
        return r;
    endfunction

    logic       zf;
    logic       bf;
    logic       cf;
    logic       lt;
    logic       take;
    logic       is_jump;
    logic       cin_hit;
    logic [3:0] alu_step;
    ctrl_word_t base;

    assign zf = word.status_flags[0];
    assign bf = word.status_flags[1];
    assign cf = !bf;
    assign lt = word.status_flags[2] ^ word.status_flags[3];

    always_comb
    begin
        case (word.opcode[2:0])
            CC_ALWAYS: take = 1'b1;
            CC_Z:      take = zf;
            CC_NZ:     take = !zf;
            CC_C:      take = cf;
            CC_NC:     take = !cf;
            CC_ZB:     take = zf || bf;
            CC_LT:     take = lt;
            CC_LE:     take = zf || lt;
            default:   take = 1'b0;
        endcase
    end

    assign is_jump  = (word.opcode >= OPC_JMP_MEM) && (word.opcode < OPC_CALL)
                    && (word.microstep == 4'd1);
    assign alu_step = (word.opcode[5:3] < 3'd2) ? 4'd2 : 4'd3;
    assign cin_hit  = (word.opcode < OPC_SHIFT_BASE) && (word.microstep == alu_step)
                    && (((word.opcode[2:0] == FN_ADC) && cf)
                        || ((word.opcode[2:0] == FN_SBB) && !cf));
    assign base     = template_word(word.opcode, word.microstep) ^ LOW_LINES;

    always_comb
    begin
        if (word.irq_pending)
        begin
            control_word = irq_word(word.microstep) ^ LOW_LINES;
        end
        else
        begin
            control_word = base ^ ((is_jump && take) ? W_PCLD : '0)
                                ^ (cin_hit ? W_CIN : '0);
        end
    end
endmodule

// ----- rtl/mcwd_out_stage.sv -----
module mcwd_out_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 valid,
    input  mcwd_pkg::ctrl_word_t word,
    output logic                 ready,
    mcwd_rsp_if.source           result
);
    import mcwd_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    ctrl_word_t word_reg;
    logic       load;

    assign ready = !valid_reg || result.ready;
    assign load  = valid && ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= word;
        end
    end

    assign result.valid        = valid_reg;
    assign result.control_word = word_reg;
endmodule

// ----- rtl/microcode_control_word_decoder_unit.sv -----
// channel   role    fields
// request   sink    irq_pending, status_flags, opcode, microstep
// result    source  control_word
//
// one word per cycle sustained while result is not stalled; path from request to result:
// input register, single-pass lookup logic, result register
// rst_n clears both valid flags asynchronously, data registers keep no reset value
// a stalled result holds its word; request stays ready while the input register can drain
module microcode_control_word_decoder_unit (
    input  logic      clk,
    input  logic      rst_n,
    mcwd_req_if.sink  request,
    mcwd_rsp_if.source result
);
    import mcwd_pkg::*;

    logic       in_valid;
    logic       out_ready;
    req_word_t  in_word;
    ctrl_word_t lookup_word;

    mcwd_in_stage u_in_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .advance (out_ready),
        .valid   (in_valid),
        .word    (in_word)
    );

    mcwd_decode u_decode (
        .word         (in_word),
        .control_word (lookup_word)
    );

    mcwd_out_stage u_out_stage (
        .clk    (clk),
        .rst_n  (rst_n),
        .valid  (in_valid),
        .word   (lookup_word),
        .ready  (out_ready),
        .result (result)
    );
endmodule

// ----- rtl/mcwd_checker.sv -----
`include "microcode_control_word_decoder_unit_defines.svh"

module mcwd_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 req_valid,
    input logic                 req_ready,
    input logic                 rsp_valid,
    input logic                 rsp_ready,
    input mcwd_pkg::ctrl_word_t rsp_word
);
    import mcwd_pkg::*;

    `MCWD_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid)
    `MCWD_ASSERT_NEXT(a_rsp_stable, clk, rst_n, rsp_valid && !rsp_ready, $stable(rsp_word))
    `MCWD_ASSERT_IMPL(a_req_open, clk, rst_n, !rsp_valid, req_ready)
    `MCWD_ASSERT_IMPL(a_latency, clk, rst_n, req_valid && req_ready, ##2 rsp_valid)
endmodule

bind microcode_control_word_decoder_unit mcwd_checker u_mcwd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (request.valid),
    .req_ready (request.ready),
    .rsp_valid (result.valid),
    .rsp_ready (result.ready),
    .rsp_word  (result.control_word)
);
